FILE: hw/rtl/dsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, constants and helpers of the DAG shortest path unit.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int NODE_W         = 12;
    localparam int WEIGHT_W       = 16;
    localparam int OUT_W          = 32;
    localparam int EPOCH_W        = 8;
    localparam int PADDR_W        = 3;
    localparam int MAX_NODES_DEF  = 4096;
    localparam int DIST_WIDTH_DEF = 32;

    localparam logic [NODE_W-1:0] NODE_MAX  = '1;
    localparam int unsigned       UNREACHED = 999999;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_DEST   = 1'b1;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // last field in the low bits
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   to_node;
        logic [NODE_W-1:0]   from_node;
    } edge_t;

    function automatic logic node_in_range(logic [NODE_W-1:0] node, int unsigned limit);
        return 32'(node) < 32'(limit);
    endfunction

endpackage

FILE: hw/rtl/dag_shortest_path_dp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_shortest_path_dp_unit
// Shortest distance to a fixed destination over forward-edged DAG edge runs.
// ----------------------------------------------------------------------------
// An edge item's accept cycle reads the source and target entries of the
// distance memory, the next cycle relaxes and writes the source entry back;
// the next item is taken only after that write, so no two memory accesses of
// different items overlap. A finish item reads the source node's entry when
// accepted and is reported once the output register is free. Entries are
// tagged with an 8-bit run epoch instead of per-entry valid bits; after reset
// and after every 255th finish item a clearing pass sweeps every entry of the
// memory, during which no item is accepted (APB writes still are).
module dag_shortest_path_dp_unit #(
    parameter int MAX_NODES  = dsp_pkg::MAX_NODES_DEF,
    parameter int DIST_WIDTH = dsp_pkg::DIST_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // from_node[11:0], to_node, weight
    input  logic                        s_tuser,   // kind
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // distance
    output logic                        m_tuser    // order_violation
);

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EPW    = dsp_pkg::EPOCH_W;
    localparam int MEM_W  = DIST_WIDTH + EPW;
    localparam logic [DIST_WIDTH-1:0] UNREACHED_D = DIST_WIDTH'(dsp_pkg::UNREACHED);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_EDGE   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [EPW-1:0]              epoch_reg, epoch_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic [dsp_pkg::NODE_W-1:0]  prev_from_reg, prev_from_next;
    logic                        viol_reg, viol_next;
    dsp_pkg::edge_t              item_reg, item_next;
    logic [dsp_pkg::NODE_W-1:0]  source_reg, source_next;
    logic [dsp_pkg::NODE_W-1:0]  dest_reg, dest_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [31:0]                 m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    dsp_pkg::edge_t              s_item;
    logic                        s_accept;
    logic                        cfg_wr;
    logic [ADDR_W-1:0]           rd_addr_a;
    logic [MEM_W-1:0]            rd_data_a;
    logic [MEM_W-1:0]            rd_data_b;
    logic                        mem_wr_en;
    logic [ADDR_W-1:0]           mem_wr_addr;
    logic [MEM_W-1:0]            mem_wr_data;
    logic                        relax_wr_en;
    logic [DIST_WIDTH-1:0]       relax_dist;
    logic [DIST_WIDTH-1:0]       src_dist;
    logic [63:0]                 src_dist64;
    logic                        out_free;

    assign s_item   = dsp_pkg::edge_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == dsp_pkg::REG_DEST) ? 32'(dest_reg) : 32'(source_reg);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign rd_addr_a = (s_tuser == dsp_pkg::KIND_FINISH) ? ADDR_W'(source_reg)
                                                         : ADDR_W'(s_item.from_node);

    dsp_dist_mem #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .aclk      (aclk),
        .rd_en     (s_accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (ADDR_W'(s_item.to_node)),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data)
    );

    dsp_relax #(
        .MAX_NODES  (MAX_NODES),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_relax (
        .item       (item_reg),
        .dest_node  (dest_reg),
        .epoch      (epoch_reg),
        .from_entry (rd_data_a),
        .to_entry   (rd_data_b),
        .wr_en      (relax_wr_en),
        .wr_dist    (relax_dist)
    );

    always_comb begin
        mem_wr_en   = (state_reg == ST_CLEAR) || ((state_reg == ST_EDGE) && relax_wr_en);
        mem_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : ADDR_W'(item_reg.from_node);
        mem_wr_data = (state_reg == ST_CLEAR) ? '0 : {epoch_reg, relax_dist};
    end

    always_comb begin
        if (source_reg == dest_reg) begin
            src_dist = '0;
        end else if (dsp_pkg::node_in_range(source_reg, MAX_NODES)
                     && (rd_data_a[MEM_W-1 -: EPW] == epoch_reg)) begin
            src_dist = rd_data_a[DIST_WIDTH-1:0];
        end else begin
            src_dist = UNREACHED_D;
        end
        src_dist64 = 64'(src_dist);
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        clr_addr_next  = clr_addr_reg;
        prev_from_next = prev_from_reg;
        viol_next      = viol_reg;
        item_next      = item_reg;
        source_next    = source_reg;
        dest_next      = dest_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_wr) begin
            if (paddr[2] == dsp_pkg::REG_SOURCE) begin
                source_next = pwdata[dsp_pkg::NODE_W-1:0];
            end else begin
                dest_next = pwdata[dsp_pkg::NODE_W-1:0];
            end
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_NODES - 1)) begin
                    clr_addr_next = '0;
                    epoch_next    = EPW'(1);
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    item_next  = s_item;
                    state_next = (s_tuser == dsp_pkg::KIND_FINISH) ? ST_FINISH : ST_EDGE;
                end
            end
            ST_EDGE: begin
                if ((item_reg.to_node <= item_reg.from_node)
                    || (item_reg.from_node > prev_from_reg)) begin
                    viol_next = 1'b1;
                end
                prev_from_next = item_reg.from_node;
                state_next     = ST_IDLE;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = (|src_dist64[63:32]) ? '1 : src_dist64[31:0];
                    m_tuser_next   = viol_reg;
                    viol_next      = 1'b0;
                    prev_from_next = dsp_pkg::NODE_MAX;
                    if (epoch_reg == '1) begin
                        state_next = ST_CLEAR;
                    end else begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= EPW'(1);
            clr_addr_reg  <= '0;
            prev_from_reg <= dsp_pkg::NODE_MAX;
            viol_reg      <= 1'b0;
            source_reg    <= '0;
            dest_reg      <= dsp_pkg::NODE_MAX;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            clr_addr_reg  <= clr_addr_next;
            prev_from_reg <= prev_from_next;
            viol_reg      <= viol_next;
            source_reg    <= source_next;
            dest_reg      <= dest_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // a relaxed entry always beats an unreached one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EDGE && relax_wr_en) |-> (relax_dist < UNREACHED_D))
        else $error("relaxed distance not below unreached value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_EDGE || state_reg == ST_CLEAR))
        else $error("distance memory written outside edge or clear");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free)
        |=> (!viol_reg && prev_from_reg == dsp_pkg::NODE_MAX && m_tvalid_reg))
        else $error("run state not reset after report");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |-> (epoch_reg != '0))
        else $error("epoch collides with cleared tag");

endmodule

FILE: hw/rtl/dsp_dist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_dist_mem
// Distance store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module dsp_dist_mem #(
    parameter int DEPTH  = dsp_pkg::MAX_NODES_DEF,
    parameter int ADDR_W = 12,
    parameter int DATA_W = dsp_pkg::DIST_WIDTH_DEF + dsp_pkg::EPOCH_W
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: hw/rtl/dsp_relax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_relax
// Edge relaxation: resolves both endpoint distances, saturating add, compare.
// ----------------------------------------------------------------------------
module dsp_relax #(
    parameter int MAX_NODES  = dsp_pkg::MAX_NODES_DEF,
    parameter int DIST_WIDTH = dsp_pkg::DIST_WIDTH_DEF
) (
    input  dsp_pkg::edge_t                                 item,
    input  logic [dsp_pkg::NODE_W-1:0]                     dest_node,
    input  logic [dsp_pkg::EPOCH_W-1:0]                    epoch,
    input  logic [DIST_WIDTH+dsp_pkg::EPOCH_W-1:0]         from_entry,
    input  logic [DIST_WIDTH+dsp_pkg::EPOCH_W-1:0]         to_entry,
    output logic                                           wr_en,
    output logic [DIST_WIDTH-1:0]                          wr_dist
);

    localparam int MEM_W = DIST_WIDTH + dsp_pkg::EPOCH_W;
    localparam logic [DIST_WIDTH-1:0] UNREACHED_D = DIST_WIDTH'(dsp_pkg::UNREACHED);

    logic                  from_in;
    logic                  to_in;
    logic                  from_valid;
    logic                  to_valid;
    logic [DIST_WIDTH-1:0] to_dist;
    logic [DIST_WIDTH-1:0] cur_dist;
    logic [DIST_WIDTH:0]   sum;
    logic [DIST_WIDTH-1:0] new_dist;

    always_comb begin
        from_in    = dsp_pkg::node_in_range(item.from_node, MAX_NODES);
        to_in      = dsp_pkg::node_in_range(item.to_node, MAX_NODES);
        from_valid = from_in && (from_entry[MEM_W-1 -: dsp_pkg::EPOCH_W] == epoch);
        to_valid   = to_in && (to_entry[MEM_W-1 -: dsp_pkg::EPOCH_W] == epoch);

        if (item.to_node == dest_node) begin
            to_dist = '0;
        end else if (to_valid) begin
            to_dist = to_entry[DIST_WIDTH-1:0];
        end else begin
            to_dist = UNREACHED_D;
        end

        cur_dist = from_valid ? from_entry[DIST_WIDTH-1:0] : UNREACHED_D;

        sum      = {1'b0, to_dist} + (DIST_WIDTH + 1)'(item.weight);
        new_dist = sum[DIST_WIDTH] ? '1 : sum[DIST_WIDTH-1:0];

        wr_en   = (item.from_node != dest_node) && from_in && (new_dist < cur_dist);
        wr_dist = new_dist;
    end

endmodule
